// File: hdl/plfbp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// plfbp_pkg
// Shared types and codes of the per-LUN free block pool: command and result
// payloads, operation and status codes, register indexes, sequencer states.
// ============================================================================
package plfbp_pkg;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int CH_W    = 4;
    localparam int LUN_W   = 3;
    localparam int BLK_W   = 10;
    localparam int RND_W   = 16;
    localparam int CNT_O_W = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_CH_W   = 5;
    localparam int CFG_LUN_W  = 4;
    localparam int CFG_BLK_W  = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LUNS_PER_CHANNEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_LUN   = 2'd2;

    localparam logic [CFG_CH_W-1:0]  CFG_CH_RESET  = 5'd16;
    localparam logic [CFG_LUN_W-1:0] CFG_LUN_RESET = 4'd8;
    localparam logic [CFG_BLK_W-1:0] CFG_BLK_RESET = 11'd1024;

    // Operation codes; the fourth code leaves the pool untouched
    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_GET  = 2'd1,
        OP_PUT  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_EMPTY  = 2'd1,
        STATUS_FULL   = 2'd2,
        STATUS_RANGE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [CH_W-1:0]  channel;
        logic [LUN_W-1:0] lun;
        logic [BLK_W-1:0] block;
        logic             is_bad;
        logic             first_of_table;
        logic [RND_W-1:0] random_value;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [BLK_W-1:0]   block_out;
        logic [CNT_O_W-1:0] free_count;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CNT_RD,
        S_EXEC,
        S_MOD,
        S_RD_PICK,
        S_PICK,
        S_DONE
    } state_t;

endpackage

// File: hdl/plfbp_mod_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// plfbp_mod_unit
// Serial remainder unit: random value modulo the free count, one dividend
// bit per cycle by restoring subtraction.
// ============================================================================
module plfbp_mod_unit #(
    parameter int CNT_W  = 11,
    parameter int SLOT_W = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [plfbp_pkg::RND_W-1:0] dividend,
    input  logic [CNT_W-1:0]            divisor,
    output logic                        done,
    output logic [SLOT_W-1:0]           remainder
);

    localparam int STEP_W = $clog2(plfbp_pkg::RND_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(plfbp_pkg::RND_W - 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [plfbp_pkg::RND_W-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0]            dvs_reg, dvs_next;
    logic [CNT_W-1:0]            rem_reg, rem_next;
    logic [CNT_W:0]              trial;

    // Shift one dividend bit into the partial remainder, subtract if it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[plfbp_pkg::RND_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[plfbp_pkg::RND_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
                rem_next = CNT_W'(trial - {1'b0, dvs_reg});
            else
                rem_next = CNT_W'(trial);
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Hold operands
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = SLOT_W'(rem_reg);

endmodule

// File: hdl/plfbp_count_store.sv
`timescale 1ns / 1ps
// ============================================================================
// plfbp_count_store
// Free count of every pool: a memory with registered read and one valid
// flop per pool, so a pool never written since reset reads as zero.
// ============================================================================
module plfbp_count_store #(
    parameter int POOLS  = 128,
    parameter int POOL_W = 7,
    parameter int CNT_W  = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [POOL_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [POOL_W-1:0] wr_addr,
    input  logic [CNT_W-1:0]  wr_data,
    output logic [CNT_W-1:0]  rd_count
);

    logic [CNT_W-1:0] mem [POOLS];
    logic [POOLS-1:0] valid_reg;
    logic [CNT_W-1:0] rdata_reg;
    logic             rvalid_reg;

    // Write and read the count memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    // Mark pools written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            rvalid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_count = rvalid_reg ? rdata_reg : '0;

endmodule

// File: hdl/per_lun_free_block_pool_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// per_lun_free_block_pool_unit
// Free block pool per flash LUN with random pick on allocation.
// ============================================================================
// Usage:
//   Raise start with a command on cmd while busy is low; the command is
//   taken at that edge and busy stays high until the result is out.
//   Operations: load one bad-block-table entry, get a free block (slot picked
//   by random_value modulo the free count, last entry moved into the hole),
//   put a block back. Pool index is channel * luns_per_channel + lun.
//   The result shows on result, flagged by done, which is high for exactly
//   one cycle; the receiver must take it then, as there is no back-pressure.
//   done follows check, count read and execute for load, put, operation
//   three and an empty get, check alone for a bad address, and for a get
//   that hands out a block also the serial remainder unit (one bit of the
//   16-bit random value per cycle), a pick read and the pick. busy drops in
//   the cycle after done, so the next command is taken then at best.
//   Configuration: cfg_write, cfg_index, cfg_data; write only while idle.
//   Reset restores the register defaults and empties every pool at once
//   (valid flop per pool). Slot memory contents are never cleared.
// ============================================================================
module per_lun_free_block_pool_unit #(
    parameter int MAX_CHANNELS         = 16,
    parameter int MAX_LUNS_PER_CHANNEL = 8,
    parameter int MAX_LUN_BLOCKS       = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  plfbp_pkg::cmd_t                  cmd,
    output logic                             done,
    output plfbp_pkg::result_t               result,
    input  logic                             cfg_write,
    input  logic [plfbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plfbp_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int POOLS  = MAX_CHANNELS * MAX_LUNS_PER_CHANNEL;
    localparam int POOL_W = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int CNT_W  = $clog2(MAX_LUN_BLOCKS + 1);
    localparam int SLOT_W = $clog2(MAX_LUN_BLOCKS);
    localparam int DEPTH  = POOLS * MAX_LUN_BLOCKS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PIDX_W = plfbp_pkg::CH_W + plfbp_pkg::CFG_LUN_W + 1;

    plfbp_pkg::state_t  state_reg, state_next;
    plfbp_pkg::cmd_t    cmd_reg;
    plfbp_pkg::result_t res_reg, res_next;

    logic [plfbp_pkg::CFG_CH_W-1:0]  cfg_ch_reg;
    logic [plfbp_pkg::CFG_LUN_W-1:0] cfg_lun_reg;
    logic [plfbp_pkg::CFG_BLK_W-1:0] cfg_blk_reg;

    logic [POOL_W-1:0]           pool_reg;
    logic [ADDR_W-1:0]           base_reg;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [SLOT_W-1:0]           slot_reg;
    logic [plfbp_pkg::BLK_W-1:0] last_reg;

    // Address decode
    logic [plfbp_pkg::CFG_LUN_W-1:0] nlun;
    logic [plfbp_pkg::CFG_BLK_W-1:0] cap;
    logic [PIDX_W-1:0]               pool_full;
    logic                            out_of_range;

    // Execute decode
    logic [CNT_W-1:0] cnt_cur;
    logic [CNT_W-1:0] c0;
    logic             append;
    logic             fits;

    // Slot memory
    logic [plfbp_pkg::BLK_W-1:0] slot_mem [DEPTH];
    logic [plfbp_pkg::BLK_W-1:0] slot_rdata_reg;
    logic                        slot_we, slot_re;
    logic [ADDR_W-1:0]           slot_waddr, slot_raddr;
    logic [plfbp_pkg::BLK_W-1:0] slot_wdata;

    // Count store and remainder unit links
    logic             cnt_we;
    logic [CNT_W-1:0] cnt_wdata;
    logic             mod_start, mod_done;
    logic [SLOT_W-1:0] mod_rem;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch_reg  <= plfbp_pkg::CFG_CH_RESET;
            cfg_lun_reg <= plfbp_pkg::CFG_LUN_RESET;
            cfg_blk_reg <= plfbp_pkg::CFG_BLK_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                plfbp_pkg::CFG_CHANNELS_IN_USE:
                    cfg_ch_reg <= plfbp_pkg::CFG_CH_W'(cfg_data);
                plfbp_pkg::CFG_LUNS_PER_CHANNEL:
                    cfg_lun_reg <= plfbp_pkg::CFG_LUN_W'(cfg_data);
                plfbp_pkg::CFG_BLOCKS_PER_LUN:
                    cfg_blk_reg <= plfbp_pkg::CFG_BLK_W'(cfg_data);
                default:
                    ;
            endcase
        end
    end

    // Clamp registers to the built size and form the pool index
    always_comb
    begin
        nlun = (32'(cfg_lun_reg) > MAX_LUNS_PER_CHANNEL) ?
               plfbp_pkg::CFG_LUN_W'(MAX_LUNS_PER_CHANNEL) : cfg_lun_reg;
        cap  = (32'(cfg_blk_reg) > MAX_LUN_BLOCKS) ?
               plfbp_pkg::CFG_BLK_W'(MAX_LUN_BLOCKS) : cfg_blk_reg;
        pool_full = PIDX_W'(cmd_reg.channel) * PIDX_W'(nlun) + PIDX_W'(cmd_reg.lun);
        out_of_range = (32'(cmd_reg.channel) >= 32'(cfg_ch_reg))
                    || (32'(cmd_reg.channel) >= MAX_CHANNELS)
                    || (32'(cmd_reg.lun) >= 32'(nlun))
                    || (32'(pool_full) >= POOLS);
    end

    // Load or put decode on the count just read
    always_comb
    begin
        c0 = (cmd_reg.operation == plfbp_pkg::OP_LOAD && cmd_reg.first_of_table)
             ? '0 : cnt_cur;
        append = (cmd_reg.operation == plfbp_pkg::OP_PUT)
              || (cmd_reg.operation == plfbp_pkg::OP_LOAD && !cmd_reg.is_bad);
        fits = 32'(c0) < 32'(cap);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plfbp_pkg::S_IDLE:
                if (start)
                    state_next = plfbp_pkg::S_CHECK;
            plfbp_pkg::S_CHECK:
                state_next = out_of_range ? plfbp_pkg::S_DONE : plfbp_pkg::S_CNT_RD;
            plfbp_pkg::S_CNT_RD:
                state_next = plfbp_pkg::S_EXEC;
            plfbp_pkg::S_EXEC:
                if (cmd_reg.operation == plfbp_pkg::OP_GET && cnt_cur != '0)
                    state_next = plfbp_pkg::S_MOD;
                else
                    state_next = plfbp_pkg::S_DONE;
            plfbp_pkg::S_MOD:
                if (mod_done)
                    state_next = plfbp_pkg::S_RD_PICK;
            plfbp_pkg::S_RD_PICK:
                state_next = plfbp_pkg::S_PICK;
            plfbp_pkg::S_PICK:
                state_next = plfbp_pkg::S_DONE;
            plfbp_pkg::S_DONE:
                state_next = plfbp_pkg::S_IDLE;
            default:
                state_next = plfbp_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory strobes, unit start, result
    always_comb
    begin
        slot_we    = 1'b0;
        slot_re    = 1'b0;
        slot_waddr = base_reg + ADDR_W'(c0);
        slot_raddr = base_reg + ADDR_W'(slot_reg);
        slot_wdata = cmd_reg.block;
        cnt_we     = 1'b0;
        cnt_wdata  = cnt_cur;
        cnt_next   = cnt_reg;
        mod_start  = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            plfbp_pkg::S_CHECK:
            begin
                res_next.status     = plfbp_pkg::STATUS_RANGE;
                res_next.block_out  = '0;
                res_next.free_count = '0;
            end
            plfbp_pkg::S_EXEC:
            begin
                cnt_next            = cnt_cur;
                res_next.status     = plfbp_pkg::STATUS_OK;
                res_next.block_out  = '0;
                res_next.free_count = plfbp_pkg::CNT_O_W'(cnt_cur);
                if (cmd_reg.operation == plfbp_pkg::OP_LOAD
                    || cmd_reg.operation == plfbp_pkg::OP_PUT)
                begin
                    slot_we   = append && fits;
                    cnt_we    = 1'b1;
                    cnt_wdata = c0 + CNT_W'(append && fits);
                    res_next.free_count = plfbp_pkg::CNT_O_W'(cnt_wdata);
                    if (append && !fits)
                        res_next.status = plfbp_pkg::STATUS_FULL;
                end
                else if (cmd_reg.operation == plfbp_pkg::OP_GET)
                begin
                    if (cnt_cur == '0)
                        res_next.status = plfbp_pkg::STATUS_EMPTY;
                    else
                    begin
                        mod_start  = 1'b1;
                        slot_re    = 1'b1;
                        slot_raddr = base_reg + ADDR_W'(cnt_cur - 1'b1);
                    end
                end
            end
            plfbp_pkg::S_RD_PICK:
                slot_re = 1'b1;
            plfbp_pkg::S_PICK:
            begin
                slot_we    = 1'b1;
                slot_waddr = base_reg + ADDR_W'(slot_reg);
                slot_wdata = last_reg;
                cnt_we     = 1'b1;
                cnt_wdata  = cnt_reg - 1'b1;
                res_next.status     = plfbp_pkg::STATUS_OK;
                res_next.block_out  = slot_rdata_reg;
                res_next.free_count = plfbp_pkg::CNT_O_W'(cnt_wdata);
            end
            default:
                ;
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= plfbp_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == plfbp_pkg::S_IDLE && start)
            cmd_reg <= cmd;
        if (state_reg == plfbp_pkg::S_CHECK)
            pool_reg <= POOL_W'(pool_full);
        if (state_reg == plfbp_pkg::S_CNT_RD)
            base_reg <= ADDR_W'(pool_reg * MAX_LUN_BLOCKS);
        if (state_reg == plfbp_pkg::S_MOD && mod_done)
            slot_reg <= mod_rem;
        if (state_reg == plfbp_pkg::S_RD_PICK)
            last_reg <= slot_rdata_reg;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    // Slot memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        if (slot_re)
            slot_rdata_reg <= slot_mem[slot_raddr];
    end

    plfbp_count_store #(
        .POOLS  (POOLS),
        .POOL_W (POOL_W),
        .CNT_W  (CNT_W)
    ) u_count_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (pool_reg),
        .wr_en    (cnt_we),
        .wr_addr  (pool_reg),
        .wr_data  (cnt_wdata),
        .rd_count (cnt_cur)
    );

    plfbp_mod_unit #(
        .CNT_W  (CNT_W),
        .SLOT_W (SLOT_W)
    ) u_mod_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (cmd_reg.random_value),
        .divisor   (cnt_cur),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign busy   = (state_reg != plfbp_pkg::S_IDLE);
    assign done   = (state_reg == plfbp_pkg::S_DONE);
    assign result = res_reg;

endmodule

// File: tb/sv/per_lun_free_block_pool_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// per_lun_free_block_pool_unit_tb
// Self-checking bench for the per-LUN free block pool. A queue of commands,
// register writes and drain points feeds a clocked driver; a clocked monitor
// keeps its own copy of every pool, predicts each result at the command
// transfer and checks the done strobe against the oldest prediction.
// A short directed run covers the corner cases; random phases follow under
// changing register settings, with random gaps between commands except in one back-to-back phase.
// ============================================================================
module per_lun_free_block_pool_unit_tb;
    import plfbp_pkg::*;

    localparam int MAX_CH       = 16;
    localparam int MAX_LUN      = 8;
    localparam int MAX_BLK      = 1024;
    localparam int POOL_CNT     = MAX_CH * MAX_LUN;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 11;
    localparam int PHASE_ITEMS  = 155;

    // Fourth operation code: touches nothing
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    typedef enum logic [1:0] {
        ITEM_CMD,
        ITEM_CFG,
        ITEM_HOLD
    } item_kind_t;

    typedef struct {
        item_kind_t            kind;
        cmd_t                  cmd;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        int unsigned           gap;
    } stim_item_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    cmd_t                  cmd       = '0;
    logic                  done;
    result_t               result;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Stimulus backlog and expected pool results
    stim_item_t  stim_backlog [$];
    result_t     pool_results_due [$];

    // Shadow copy of the registers and the pools
    logic [CFG_CH_W-1:0]  chan_reg = CFG_CH_RESET;
    logic [CFG_LUN_W-1:0] lun_reg  = CFG_LUN_RESET;
    logic [CFG_BLK_W-1:0] cap_reg  = CFG_BLK_RESET;
    logic [BLK_W-1:0]     slot_mem [POOL_CNT*MAX_BLK];
    logic [CNT_O_W-1:0]   fill_cnt [POOL_CNT] = '{default: '0};

    // Effective settings seen by the stimulus generator
    int unsigned gen_nch  = MAX_CH;
    int unsigned gen_nlun = MAX_LUN;
    int unsigned gen_cap  = MAX_BLK;

    int          mismatches   = 0;
    int          quiet_cycles = 0;
    int unsigned gap_left     = 0;
    logic        start_nxt;
    logic        write_nxt;
    logic        link_idle;
    stim_item_t  head;
    result_t     exp_res;

    per_lun_free_block_pool_unit #(
        .MAX_CHANNELS         (MAX_CH),
        .MAX_LUNS_PER_CHANNEL (MAX_LUN),
        .MAX_LUN_BLOCKS       (MAX_BLK)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
        return (v > hi) ? hi : v;
    endfunction

    // Apply one command to the shadow pools and return the result it gives
    function automatic result_t compute_pool_result(input cmd_t c);
        int unsigned nch;
        int unsigned nlun;
        int unsigned cap;
        int unsigned pool;
        int unsigned base;
        int unsigned cnt;
        int unsigned slot;
        result_t     r;
        nch  = clamp_to(chan_reg, MAX_CH);
        nlun = clamp_to(lun_reg, MAX_LUN);
        cap  = clamp_to(cap_reg, MAX_BLK);
        r.status     = STATUS_OK;
        r.block_out  = '0;
        r.free_count = '0;
        if (c.channel >= nch || c.lun >= nlun)
        begin
            r.status = STATUS_RANGE;
            return r;
        end
        pool = c.channel * nlun + c.lun;
        base = pool * MAX_BLK;
        cnt  = fill_cnt[pool];
        if (c.operation == OP_LOAD || c.operation == OP_PUT)
        begin
            if (c.operation == OP_LOAD && c.first_of_table)
                cnt = 0;
            // Bad blocks from the table are never appended
            if (c.operation == OP_PUT || !c.is_bad)
            begin
                if (cnt < cap)
                begin
                    slot_mem[base + cnt] = c.block;
                    cnt++;
                end
                else
                    r.status = STATUS_FULL;
            end
        end
        else if (c.operation == OP_GET)
        begin
            if (cnt == 0)
                r.status = STATUS_EMPTY;
            else
            begin
                // Hand out the picked slot and fill the hole with the last entry
                slot = c.random_value % cnt;
                r.block_out = slot_mem[base + slot];
                slot_mem[base + slot] = slot_mem[base + cnt - 1];
                cnt--;
            end
        end
        fill_cnt[pool] = CNT_O_W'(cnt);
        r.free_count   = CNT_O_W'(cnt);
        return r;
    endfunction

    // Mostly back-to-back, sometimes short gaps, a few long ones
    function automatic int unsigned pick_gap(input bit tight);
        int unsigned r;
        if (tight)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    task automatic queue_cmd(input logic [OP_W-1:0] op, input int unsigned ch,
                             input int unsigned ln, input int unsigned blk, input bit bad,
                             input bit first, input int unsigned rnd, input bit tight);
        stim_item_t it;
        it.kind                = ITEM_CMD;
        it.cmd.operation       = op;
        it.cmd.channel         = CH_W'(ch);
        it.cmd.lun             = LUN_W'(ln);
        it.cmd.block           = BLK_W'(blk);
        it.cmd.is_bad          = bad;
        it.cmd.first_of_table  = first;
        it.cmd.random_value    = RND_W'(rnd);
        it.idx                 = '0;
        it.data                = '0;
        it.gap                 = pick_gap(tight);
        stim_backlog.push_back(it);
    endtask

    // Wait point: the driver stalls here until every result is back
    task automatic queue_hold();
        stim_item_t it;
        it.kind = ITEM_HOLD;
        it.cmd  = '0;
        it.idx  = '0;
        it.data = '0;
        it.gap  = 0;
        stim_backlog.push_back(it);
    endtask

    task automatic queue_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        stim_item_t it;
        it.kind = ITEM_CFG;
        it.cmd  = '0;
        it.idx  = idx;
        it.data = CFG_DATA_W'(val);
        it.gap  = 0;
        stim_backlog.push_back(it);
        case (idx)
            CFG_CHANNELS_IN_USE:  gen_nch  = clamp_to(val, MAX_CH);
            CFG_LUNS_PER_CHANNEL: gen_nlun = clamp_to(val, MAX_LUN);
            CFG_BLOCKS_PER_LUN:   gen_cap  = clamp_to(val, MAX_BLK);
            default: ;
        endcase
    endtask

    task automatic queue_setting(input int unsigned nch, input int unsigned nlun,
                                 input int unsigned cap);
        queue_hold();
        queue_cfg(CFG_CHANNELS_IN_USE, nch);
        queue_cfg(CFG_LUNS_PER_CHANNEL, nlun);
        queue_cfg(CFG_BLOCKS_PER_LUN, cap);
    endtask

    // Pick an address in range, or a stray one when asked and possible
    task automatic pick_address(input bit stray, output int unsigned ch,
                                output int unsigned ln);
        ch = $urandom_range(15, 0);
        ln = $urandom_range(7, 0);
        if (gen_nch == 0 || gen_nlun == 0)
            return;
        if (stray && (gen_nch < 16 || gen_nlun < 8))
        begin
            if (gen_nch < 16 && (gen_nlun == 8 || $urandom_range(1, 0) == 1))
                ch = $urandom_range(15, gen_nch);
            else
                ln = $urandom_range(7, gen_nlun);
            return;
        end
        ch = $urandom_range(gen_nch - 1, 0);
        ln = $urandom_range(gen_nlun - 1, 0);
    endtask

    // Random traffic: table loads in bursts, gets, puts, single loads and fourth-code commands, mostly on live pools
    task automatic queue_random_phase(input int unsigned n_items, input bit tight);
        int unsigned count;
        int unsigned len;
        int unsigned ch;
        int unsigned ln;
        int unsigned pick;
        int unsigned k;
        count = 0;
        while (count < n_items)
        begin
            pick = $urandom_range(99, 0);
            pick_address(pick >= 95, ch, ln);
            if (pick < 12)
            begin
                len = $urandom_range((gen_cap > 14) ? 16 : gen_cap + 2, 1);
                for (k = 0; k < len; k++)
                    queue_cmd(OP_LOAD, ch, ln, $urandom_range(1023, 0),
                              $urandom_range(4, 0) == 0, k == 0,
                              $urandom_range(65535, 0), tight);
                count += len;
            end
            else
            begin
                if (pick < 50)
                    queue_cmd(OP_GET, ch, ln, $urandom_range(1023, 0),
                              $urandom_range(1, 0), $urandom_range(1, 0),
                              $urandom_range(65535, 0), tight);
                else if (pick < 82)
                    queue_cmd(OP_PUT, ch, ln, $urandom_range(1023, 0),
                              $urandom_range(1, 0), $urandom_range(1, 0),
                              $urandom_range(65535, 0), tight);
                else if (pick < 90)
                    queue_cmd(OP_LOAD, ch, ln, $urandom_range(1023, 0),
                              $urandom_range(3, 0) == 0, $urandom_range(7, 0) == 0,
                              $urandom_range(65535, 0), tight);
                else if (pick < 95)
                    queue_cmd(OP_NOP, ch, ln, $urandom_range(1023, 0),
                              $urandom_range(1, 0), $urandom_range(1, 0),
                              $urandom_range(65535, 0), tight);
                else
                    queue_cmd($urandom_range(3, 0), ch, ln, $urandom_range(1023, 0),
                              $urandom_range(1, 0), $urandom_range(1, 0),
                              $urandom_range(65535, 0), tight);
                count++;
            end
            if (!tight && $urandom_range(99, 0) == 0)
                queue_hold();
        end
    endtask

    // Build the whole stimulus, release reset, then wait for the drain
    initial
    begin
        int unsigned p;
        int unsigned ch_v;
        int unsigned ln_v;
        int unsigned cap_v;

        // Empty pool, bad and good table entries, picks at both ends
        queue_cmd(OP_GET, 15, 7, 0, 0, 0, 16'hFFFF, 0);
        queue_cmd(OP_LOAD, 15, 7, 0, 1, 1, 0, 0);
        queue_cmd(OP_LOAD, 15, 7, 1023, 0, 1, 0, 0);
        queue_cmd(OP_LOAD, 15, 7, 0, 0, 0, 0, 0);
        queue_cmd(OP_PUT, 15, 7, 10'h2AA, 1, 1, 0, 0);
        queue_cmd(OP_GET, 15, 7, 0, 0, 0, 0, 0);
        queue_cmd(OP_GET, 15, 7, 0, 0, 0, 16'hFFFF, 0);
        queue_cmd(OP_NOP, 15, 7, 1023, 1, 1, 16'hFFFF, 0);
        queue_cmd(OP_GET, 15, 7, 0, 0, 0, 12345, 0);
        queue_cmd(OP_PUT, 0, 0, 10'h155, 0, 0, 0, 0);
        queue_cmd(OP_PUT, 0, 0, 10'h3FF, 0, 0, 0, 0);
        queue_cmd(OP_PUT, 0, 0, 0, 0, 0, 0, 0);

        // Shrink capacity below the stored count
        queue_setting(16, 8, 2);
        queue_cmd(OP_PUT, 0, 0, 7, 0, 0, 0, 0);
        queue_cmd(OP_LOAD, 0, 0, 8, 0, 0, 0, 0);
        queue_cmd(OP_GET, 0, 0, 0, 0, 0, 7, 0);
        queue_cmd(OP_GET, 0, 0, 0, 0, 0, 1, 0);

        // Smallest settings: one pool of one block
        queue_setting(1, 1, 1);
        queue_cmd(OP_PUT, 0, 0, 9, 0, 0, 0, 0);
        queue_cmd(OP_LOAD, 0, 0, 10, 1, 0, 0, 0);
        queue_cmd(OP_GET, 0, 0, 0, 0, 0, 3, 0);
        queue_cmd(OP_LOAD, 0, 0, 11, 0, 1, 0, 0);
        queue_cmd(OP_GET, 1, 0, 0, 0, 0, 0, 0);
        queue_cmd(OP_PUT, 0, 1, 12, 0, 0, 0, 0);

        // Zero registers: nothing in range, or every pool full
        queue_setting(0, 1, 1);
        queue_cmd(OP_GET, 0, 0, 0, 0, 0, 0, 0);
        queue_setting(1, 0, 1);
        queue_cmd(OP_PUT, 0, 0, 13, 0, 0, 0, 0);
        queue_setting(31, 15, 0);
        queue_cmd(OP_LOAD, 15, 7, 14, 0, 0, 0, 0);
        queue_cmd(OP_PUT, 3, 2, 15, 0, 0, 0, 0);
        queue_cmd(OP_NOP, 0, 0, 0, 0, 0, 0, 0);

        // Random phases, each under its own register setting
        for (p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                queue_setting(31, 15, 2047);
            else if (p == 1)
                queue_setting(2, 2, 6);
            else
            begin
                ch_v  = ($urandom_range(9, 0) == 0) ? 16 : $urandom_range(3, 1);
                ln_v  = ($urandom_range(9, 0) == 0) ? 8 : $urandom_range(3, 1);
                cap_v = ($urandom_range(9, 0) == 0) ? 1024 : $urandom_range(12, 1);
                queue_setting(ch_v, ln_v, cap_v);
            end
            queue_random_phase(PHASE_ITEMS, p == 1);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: backlog empty, block idle, no result outstanding
        do
            @(negedge clk);
        while (stim_backlog.size() != 0 || start || busy || pool_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pool_results_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Driver: issue commands, register writes and wait points from the backlog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            cmd       <= '0;
            cfg_write <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
            gap_left  <= 0;
        end
        else
        begin
            // Hold a command until its transfer
            start_nxt = start && busy;
            write_nxt = 1'b0;
            link_idle = !start && !busy && !done && pool_results_due.size() == 0;
            if (!start_nxt)
            begin
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
                else if (stim_backlog.size() != 0)
                begin
                    head = stim_backlog[0];
                    case (head.kind)
                        ITEM_CMD:
                        begin
                            start_nxt = 1'b1;
                            cmd      <= head.cmd;
                            gap_left <= head.gap;
                            void'(stim_backlog.pop_front());
                        end
                        ITEM_CFG:
                            if (link_idle)
                            begin
                                write_nxt = 1'b1;
                                cfg_index <= head.idx;
                                cfg_data  <= head.data;
                                void'(stim_backlog.pop_front());
                            end
                        default:
                            if (link_idle)
                                void'(stim_backlog.pop_front());
                    endcase
                end
            end
            start     <= start_nxt;
            cfg_write <= write_nxt;
        end
    end

    // Monitor: track register writes, predict on transfer, check on done
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                case (cfg_index)
                    CFG_CHANNELS_IN_USE:  chan_reg = cfg_data[CFG_CH_W-1:0];
                    CFG_LUNS_PER_CHANNEL: lun_reg  = cfg_data[CFG_LUN_W-1:0];
                    CFG_BLOCKS_PER_LUN:   cap_reg  = cfg_data[CFG_BLK_W-1:0];
                    default: ;
                endcase
            if (start && !busy)
                pool_results_due.push_back(compute_pool_result(cmd));
            if (done)
            begin
                if (pool_results_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: status %0d block_out %0d free_count %0d",
                             $time, result.status, result.block_out, result.free_count);
                end
                else
                begin
                    exp_res = pool_results_due.pop_front();
                    if (result.status !== exp_res.status)
                    begin
                        mismatches++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, exp_res.status, result.status);
                    end
                    if (result.block_out !== exp_res.block_out)
                    begin
                        mismatches++;
                        $display("%0t: block_out expected %0d, got %0d",
                                 $time, exp_res.block_out, result.block_out);
                    end
                    if (result.free_count !== exp_res.free_count)
                    begin
                        mismatches++;
                        $display("%0t: free_count expected %0d, got %0d",
                                 $time, exp_res.free_count, result.free_count);
                    end
                end
            end
        end
    end

    // Watchdog: end the run after a long stretch with no transfer at all
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
